### sv/dft_pkg.sv
// Shared types and constants for the display frame translator.
// Used by dft_cell, dft_check and display_frame_translator; depends on nothing.
package dft_pkg;

  localparam int WIN_LEN = 11;
  localparam int CNT_W   = $clog2(WIN_LEN + 1);

  typedef logic [7:0]                byte_t;
  typedef logic [WIN_LEN-1:0][7:0]   frame_t;
  typedef logic [CNT_W-1:0]          count_t;

  localparam byte_t START_BYTE = 8'h80;
  localparam byte_t STOP_BYTE  = 8'h81;
  localparam byte_t PAD_BYTE   = 8'h00;

  localparam logic [6:0] ASCII_SPACE = 7'd32;
  localparam logic [6:0] ASCII_DASH  = 7'd45;
  localparam byte_t      ASCII_ZERO  = 8'd48;
  localparam byte_t      DASH_DIGIT  = 8'd3;
  localparam byte_t      BLANK_DIGIT = 8'h7f;

  typedef enum logic [1:0] {
    AREA_CLEAR_FUNC = 2'd0,
    AREA_BLANK      = 2'd1,
    AREA_KEEP_A     = 2'd2,
    AREA_KEEP_B     = 2'd3
  } area_t;

  // Control for one byte cell of a shifting row.
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  // Result of testing and translating the window for the incoming byte.
  typedef struct packed {
    logic       hit;
    logic [6:0] check;
    logic       bf_update;
    logic [6:0] bf;
    frame_t     frame;
  } check_res_t;

endpackage

### sv/dft_cell.sv
// One byte cell of a shifting row: parallel load or take the neighbour's byte.
// Depends on dft_pkg.
module dft_cell (
  input  logic                clk,
  input  logic                rst,
  input  dft_pkg::cell_ctrl_t ctrl,
  input  dft_pkg::byte_t      load_data,
  input  dft_pkg::byte_t      shift_in,
  output dft_pkg::byte_t      data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      data <= '0;
    end else if (ctrl.load) begin
      data <= load_data;
    end else if (ctrl.shift) begin
      data <= shift_in;
    end
  end

endmodule

### sv/dft_check.sv
// Frame detection, check test and digit translation for the byte about to enter.
// Depends on dft_pkg.
module dft_check (
  input  dft_pkg::frame_t     win,
  input  dft_pkg::byte_t      in_byte,
  input  logic [6:0]          last_check,
  input  logic [6:0]          last_bf,
  output dft_pkg::check_res_t res
);

  // Space reads as zero; a dash reads as three only where allowed.
  function automatic dft_pkg::byte_t conv_digit(input logic [6:0] v, input logic dash_ok);
    dft_pkg::byte_t r;
    if (v == dft_pkg::ASCII_SPACE) begin
      r = '0;
    end else if (dash_ok && v == dft_pkg::ASCII_DASH) begin
      r = dft_pkg::DASH_DIGIT;
    end else begin
      r = {1'b0, v} - dft_pkg::ASCII_ZERO;
    end
    return r;
  endfunction

  logic [6:0]     sum;
  logic [6:0]     chk_in;
  logic [6:0]     h_raw, t_raw, u_raw, t_sel, u_sel, b_raw, f_raw, s_raw;
  logic [1:0]     area;
  dft_pkg::byte_t h, t, u, b, f, s, a, chk_out;

  // After the shift the window's oldest byte is win[1] and data bytes are win[2..9].
  always_comb begin
    sum = '0;
    for (int k = 2; k < dft_pkg::WIN_LEN - 1; k++) begin
      sum = sum ^ win[k][6:0];
    end
    chk_in = win[dft_pkg::WIN_LEN-1][6:0];
    h_raw  = win[3][6:0];
    t_raw  = win[4][6:0];
    u_raw  = win[5][6:0];
    b_raw  = win[6][6:0];
    f_raw  = win[7][6:0];
    s_raw  = win[8][6:0];
    area   = win[9][1:0];

    if (u_raw == 7'd0) begin
      u_sel = t_raw;
      t_sel = h_raw;
    end else begin
      u_sel = u_raw;
      t_sel = t_raw;
    end

    h = '0;
    t = conv_digit(t_sel, 1'b1);
    u = conv_digit(u_sel, 1'b0);
    f = {1'b0, f_raw};
    s = {1'b0, s_raw};
    a = {6'd0, area};

    case (dft_pkg::area_t'(area))
      dft_pkg::AREA_CLEAR_FUNC: f = '0;
      dft_pkg::AREA_BLANK: begin
        h = dft_pkg::BLANK_DIGIT;
        t = dft_pkg::BLANK_DIGIT;
        u = dft_pkg::BLANK_DIGIT;
      end
      default: ;
    endcase

    res.bf_update = (b_raw != 7'd0);
    res.bf        = b_raw;
    b             = res.bf_update ? {1'b0, b_raw} : {1'b0, last_bf};

    chk_out = h ^ t ^ u ^ b ^ f ^ s ^ a;

    res.hit   = (win[1] == dft_pkg::START_BYTE) && (in_byte == dft_pkg::STOP_BYTE) &&
                (chk_in == sum) && (chk_in != last_check);
    res.check = chk_in;

    res.frame[0]  = dft_pkg::START_BYTE;
    res.frame[1]  = dft_pkg::PAD_BYTE;
    res.frame[2]  = h;
    res.frame[3]  = t;
    res.frame[4]  = u;
    res.frame[5]  = b;
    res.frame[6]  = f;
    res.frame[7]  = s;
    res.frame[8]  = a;
    res.frame[9]  = chk_out;
    res.frame[10] = dft_pkg::STOP_BYTE;
  end

endmodule

### sv/display_frame_translator.sv
// Top level of the display frame translator: window row, output row and check logic.
// Depends on dft_pkg, dft_cell and dft_check.
//
// Usage. Serial bytes arrive on the input channel (in_valid, in_stall, in_byte),
// one transaction per byte. They shift through an eleven-cell window row. When
// the byte being accepted closes a valid frame (start byte, eight data bytes,
// matching check that differs from the previous accepted check, stop byte), the
// translated eleven-byte frame is loaded in the same cycle into a second row of
// cells, the output row, and then shifted out one byte per transaction on the
// output channel (out_valid, out_stall, out_byte, frame_end). frame_end marks the
// closing stop byte.
// Latency: the first output byte is offered the cycle after the closing input
// byte is accepted; the frame takes eleven output transactions.
// Throughput: one input byte per cycle. The output row holds a single frame, so
// while it is still emptying, in_stall rises only when the next byte could close
// another frame (the window byte that would become oldest is a start byte) and
// the last byte of the previous frame is not leaving in the same cycle; otherwise
// input keeps flowing at one byte a cycle.
// A stalled receiver simply holds the output row; nothing is lost.
// Reset (rst, synchronous) clears the window to zero, the output row count and
// the remembered check and basic-function values.
module display_frame_translator (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  dft_pkg::byte_t in_byte,
  output logic           out_valid,
  input  logic           out_stall,
  output dft_pkg::byte_t out_byte,
  output logic           frame_end
);

  dft_pkg::frame_t     win;
  dft_pkg::frame_t     emit;
  dft_pkg::count_t     count;
  dft_pkg::count_t     count_next;
  logic [6:0]          last_check;
  logic [6:0]          last_bf;
  dft_pkg::check_res_t res;
  dft_pkg::cell_ctrl_t win_ctrl;
  dft_pkg::cell_ctrl_t emit_ctrl;
  logic                in_acc;
  logic                out_acc;
  logic                load;

  // The output row is busy until its count drains to zero, or its last byte is
  // leaving in this cycle. Only a byte that might close a frame has to wait for it.
  assign in_stall = (count != '0) && !(frame_end && out_acc) &&
                    (win[1] == dft_pkg::START_BYTE);
  assign in_acc   = in_valid && !in_stall;
  assign out_valid = (count != '0);
  assign out_acc   = out_valid && !out_stall;
  assign out_byte  = emit[0];
  assign frame_end = (count == dft_pkg::count_t'(1));
  assign load      = in_acc && res.hit;

  assign win_ctrl.shift  = in_acc;
  assign win_ctrl.load   = 1'b0;
  assign emit_ctrl.shift = out_acc;
  assign emit_ctrl.load  = load;

  dft_check u_check (
    .win        (win),
    .in_byte    (in_byte),
    .last_check (last_check),
    .last_bf    (last_bf),
    .res        (res)
  );

  // Window row: the newest byte enters at the top cell, the oldest sits in cell 0.
  for (genvar i = 0; i < dft_pkg::WIN_LEN; i++) begin : g_win
    dft_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (win_ctrl),
      .load_data (dft_pkg::PAD_BYTE),
      .shift_in  ((i == dft_pkg::WIN_LEN - 1) ? in_byte : win[(i + 1) % dft_pkg::WIN_LEN]),
      .data      (win[i])
    );
  end

  // Output row: loaded in parallel with a translated frame, emptied from cell 0.
  for (genvar i = 0; i < dft_pkg::WIN_LEN; i++) begin : g_emit
    dft_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (emit_ctrl),
      .load_data (res.frame[i]),
      .shift_in  ((i == dft_pkg::WIN_LEN - 1) ? dft_pkg::PAD_BYTE :
                  emit[(i + 1) % dft_pkg::WIN_LEN]),
      .data      (emit[i])
    );
  end

  always_comb begin
    count_next = count;
    if (load) begin
      count_next = dft_pkg::count_t'(dft_pkg::WIN_LEN);
    end else if (out_acc) begin
      count_next = count - dft_pkg::count_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      last_check <= '0;
      last_bf    <= '0;
    end else begin
      count <= count_next;
      if (load) begin
        last_check <= res.check;
        if (res.bf_update) begin
          last_bf <= res.bf;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  // A new frame may only be loaded into an output row that is empty or losing its
  // last byte in the same cycle.
  a_load_empty: assert property (@(posedge clk) disable iff (rst)
    load |-> ((count == '0) || (frame_end && out_acc)))
    else $error("frame loaded while output row busy");

  // A loaded frame offers all eleven bytes next cycle.
  a_load_count: assert property (@(posedge clk) disable iff (rst)
    load |=> (count == dft_pkg::count_t'(dft_pkg::WIN_LEN)) && out_valid)
    else $error("output count wrong after load");

  // The closing byte of every emitted frame is the stop byte.
  a_end_stop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end) |-> (out_byte == dft_pkg::STOP_BYTE))
    else $error("frame_end not on stop byte");

  // The count never exceeds one frame.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= dft_pkg::count_t'(dft_pkg::WIN_LEN))
    else $error("output count out of range");

  // The remembered check only changes on a load.
  a_check_hold: assert property (@(posedge clk) disable iff (rst)
    !load |=> $stable(last_check))
    else $error("last check changed without a frame");
`endif

endmodule

### tb/sv/tb_display_frame_translator.sv
// Self-checking testbench for display_frame_translator: random serial byte streams in,
// translated eleven-byte display frames out, checked against a behavioural predictor.
// Depends on dft_pkg and display_frame_translator.
`timescale 1ns / 100ps

module tb_display_frame_translator;

  // Cycles in a row with no transaction on either channel before the run is abandoned.
  // A correct run never comes near this: the longest natural pause is a run of random
  // stall, plus the short drain at the very end.
  localparam int STALL_LIMIT = 2000;
  // Number of input bytes, counted from the start, after which the quiet stretch
  // (no idling on either side) begins and ends.
  localparam int QUIET_FROM  = 140;
  localparam int QUIET_TO    = 230;
  localparam int GAP_PCT     = 9;
  localparam int FEED_BYTES  = 260;

  typedef enum int {
    FRAME_CLEAN,
    FRAME_BAD_CHECK,
    FRAME_HIGH_CHECK
  } frame_kind_t;

  typedef struct packed {
    dft_pkg::byte_t value;
    logic           last;
  } due_byte_t;

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           in_valid  = 1'b0;
  logic           in_stall;
  dft_pkg::byte_t in_byte   = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  dft_pkg::byte_t out_byte;
  logic           frame_end;

  // Bytes waiting to be sent, filled once by the stimulus block before reset is released.
  dft_pkg::byte_t byte_feed [$];
  // Translated frame bytes that the block still owes us, oldest first.
  due_byte_t      due_bytes [$];

  // Predictor state: the sliding window and the two remembered values.
  dft_pkg::byte_t window_q [dft_pkg::WIN_LEN];
  logic [6:0]     prev_check = '0;
  logic [6:0]     prev_bf    = '0;

  logic in_fire = 1'b0;
  int   bytes_taken    = 0;
  int   mismatch_count = 0;
  int   dead_cycles    = 0;

  display_frame_translator dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .frame_end (frame_end)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    foreach (window_q[i]) window_q[i] = '0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Floor digit conversion. The dash is only meaningful for the tens digit.
  function automatic dft_pkg::byte_t digit_value(input dft_pkg::byte_t v, input bit dash_ok);
    if (v == {1'b0, dft_pkg::ASCII_SPACE}) return '0;
    if (dash_ok && v == {1'b0, dft_pkg::ASCII_DASH}) return dft_pkg::DASH_DIGIT;
    return v - dft_pkg::ASCII_ZERO;
  endfunction

  // Shifts one accepted byte into the predicted window. When the window closes a frame
  // that passes both check tests, the eleven translated bytes are queued as due.
  task automatic translate_window(input dft_pkg::byte_t nb);
    logic [6:0]     d [9];
    logic [6:0]     sum;
    logic [6:0]     bf;
    dft_pkg::byte_t h, t, u, f, s, chk;
    dft_pkg::byte_t outf [dft_pkg::WIN_LEN];
    dft_pkg::area_t a;
    int             k;
    for (k = 0; k < dft_pkg::WIN_LEN - 1; k++) window_q[k] = window_q[k + 1];
    window_q[dft_pkg::WIN_LEN - 1] = nb;
    if (window_q[0] != dft_pkg::START_BYTE ||
        window_q[dft_pkg::WIN_LEN - 1] != dft_pkg::STOP_BYTE) return;

    for (k = 0; k < 9; k++) d[k] = window_q[k + 1][6:0];
    sum = '0;
    for (k = 0; k < 8; k++) sum ^= d[k];
    // A bad check and a repeat of the last good check both drop the frame silently.
    if (d[8] != sum || d[8] == prev_check) return;
    prev_check = d[8];

    h  = {1'b0, d[1]};
    t  = {1'b0, d[2]};
    u  = {1'b0, d[3]};
    bf = d[4];
    f  = {1'b0, d[5]};
    s  = {1'b0, d[6]};
    a  = dft_pkg::area_t'(d[7][1:0]);

    // A missing units digit means the number is one place shorter than it looks.
    if (u == 8'h00) begin
      u = t;
      t = h;
    end
    h = '0;
    t = digit_value(t, 1'b1);
    u = digit_value(u, 1'b0);

    if (a == dft_pkg::AREA_CLEAR_FUNC) begin
      f = '0;
    end else if (a == dft_pkg::AREA_BLANK) begin
      h = dft_pkg::BLANK_DIGIT;
      t = dft_pkg::BLANK_DIGIT;
      u = dft_pkg::BLANK_DIGIT;
    end

    if (bf == 7'd0) begin
      bf = prev_bf;
    end else begin
      prev_bf = bf;
    end

    chk = h ^ t ^ u ^ {1'b0, bf} ^ f ^ s ^ {6'd0, a};

    outf = '{dft_pkg::START_BYTE, dft_pkg::PAD_BYTE, h, t, u, {1'b0, bf}, f, s,
             {6'd0, a}, chk, dft_pkg::STOP_BYTE};
    for (k = 0; k < dft_pkg::WIN_LEN; k++) begin
      due_bytes.push_back('{value: outf[k], last: (k == dft_pkg::WIN_LEN - 1)});
    end
  endtask

  // Floor digit bytes: mostly ASCII digits, with the space, the dash, zero (which
  // triggers the units fallback), a zero hidden behind bit 7, and arbitrary values.
  function automatic dft_pkg::byte_t pick_digit();
    case ($urandom_range(9))
      0:       return {1'b0, dft_pkg::ASCII_SPACE};
      1:       return {1'b0, dft_pkg::ASCII_DASH};
      2:       return 8'h00;
      3:       return 8'h80;
      4:       return 8'($urandom_range(255));
      default: return dft_pkg::ASCII_ZERO + 8'($urandom_range(9));
    endcase
  endfunction

  task automatic random_frame_data(output dft_pkg::byte_t d [8]);
    d[0] = 8'($urandom_range(255));
    d[1] = pick_digit();
    d[2] = pick_digit();
    d[3] = pick_digit();
    // The basic-function byte is zero often enough to exercise the substitution.
    if ($urandom_range(99) < 30) begin
      d[4] = ($urandom_range(1) != 0) ? 8'h80 : 8'h00;
    end else begin
      d[4] = 8'($urandom_range(255));
    end
    d[5] = 8'($urandom_range(255));
    d[6] = 8'($urandom_range(255));
    d[7] = 8'($urandom_range(255));
  endtask

  task automatic push_frame(input dft_pkg::byte_t d [8], input frame_kind_t kind);
    dft_pkg::byte_t chk;
    int             k;
    chk = '0;
    for (k = 0; k < 8; k++) chk ^= {1'b0, d[k][6:0]};
    if (kind == FRAME_BAD_CHECK) begin
      chk ^= 8'($urandom_range(1, 127));
    end else if (kind == FRAME_HIGH_CHECK) begin
      // Bit 7 is masked before the comparison, so this frame must still pass.
      chk |= 8'h80;
    end
    byte_feed.push_back(dft_pkg::START_BYTE);
    for (k = 0; k < 8; k++) byte_feed.push_back(d[k]);
    byte_feed.push_back(chk);
    byte_feed.push_back(dft_pkg::STOP_BYTE);
  endtask

  // A good frame with a start byte buried in data byte p, followed by the bytes that
  // turn the window from that start byte onwards into a second good frame.
  task automatic push_overlap();
    dft_pkg::byte_t d [8];
    dft_pkg::byte_t s [21];
    dft_pkg::byte_t chk;
    int             p, k;
    p = $urandom_range(2, 8);
    random_frame_data(d);
    d[p - 1] = dft_pkg::START_BYTE;
    s[0] = dft_pkg::START_BYTE;
    chk = '0;
    for (k = 0; k < 8; k++) begin
      s[k + 1] = d[k];
      chk ^= {1'b0, d[k][6:0]};
    end
    s[9]  = chk;
    s[10] = dft_pkg::STOP_BYTE;
    for (k = 11; k <= p + 8; k++) s[k] = 8'($urandom_range(255));
    chk = '0;
    for (k = p + 1; k <= p + 8; k++) chk ^= {1'b0, s[k][6:0]};
    s[p + 9]  = chk;
    s[p + 10] = dft_pkg::STOP_BYTE;
    for (k = 0; k <= p + 10; k++) byte_feed.push_back(s[k]);
  endtask

  function automatic int gap_pct();
    return (bytes_taken >= QUIET_FROM && bytes_taken < QUIET_TO) ? 0 : GAP_PCT;
  endfunction

  // Driver. Everything changes on the falling edge. A byte on offer is held until the
  // rising edge at which it is accepted; only then may the next one (or a gap) follow.
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || in_fire) begin
        if (byte_feed.size() != 0 && $urandom_range(99) >= gap_pct()) begin
          in_valid <= 1'b1;
          in_byte  <= byte_feed.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < gap_pct());
    end
  end

  // Monitor. Both channels are sampled on the rising edge. Output bytes are compared
  // before the input byte of the same edge is predicted; a frame closed on this edge
  // cannot appear on the output before the next one anyway.
  always @(posedge clk) begin : monitor
    due_byte_t want;
    logic      took_in, took_out;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      took_in  = in_valid && !in_stall;
      took_out = out_valid && !out_stall;
      in_fire <= took_in;

      if (took_out) begin
        if (due_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected output byte %02h frame_end %0b",
                                    out_byte, frame_end));
        end else begin
          want = due_bytes.pop_front();
          if (out_byte !== want.value)
            report_mismatch($sformatf("out_byte %02h, predicted %02h", out_byte, want.value));
          if (frame_end !== want.last)
            report_mismatch($sformatf("frame_end %0b, predicted %0b", frame_end, want.last));
        end
      end

      if (took_in) begin
        translate_window(in_byte);
        bytes_taken++;
      end

      dead_cycles = (took_in || took_out) ? 0 : dead_cycles + 1;
      if (dead_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d bytes still due",
                 STALL_LIMIT, due_bytes.size());
        $display("display_frame_translator regression: fail");
        $finish;
      end
    end
  end

  // Stimulus and end of run. The whole byte stream is built up front; the driver then
  // drains it at whatever pace the idling and the block's back-pressure allow.
  initial begin
    dft_pkg::byte_t d [8];
    int             pick, k;

    // All-zero data gives a check of zero, which equals the remembered check straight
    // after reset, so this first frame must be dropped.
    d = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    push_frame(d, FRAME_CLEAN);
    // Good frame, area code 0 clears func; check byte carries bit 7; first byte 0xff.
    d = '{8'hff, 8'h31, 8'h32, 8'h35, 8'h05, 8'h22, 8'h11, 8'h7c};
    push_frame(d, FRAME_HIGH_CHECK);
    // The very same frame again repeats the last check and is dropped.
    push_frame(d, FRAME_CLEAN);
    // Check mismatch.
    d = '{8'h00, 8'h33, 8'h2d, 8'h37, 8'h19, 8'h40, 8'h0a, 8'h02};
    push_frame(d, FRAME_BAD_CHECK);
    // Units zero (hidden behind bit 7): the dash falls to units, where it has no special
    // meaning; basic function zero takes the remembered value; area code 2.
    d = '{8'h7f, 8'h37, 8'h2d, 8'h80, 8'h80, 8'h7f, 8'h7f, 8'hfe};
    push_frame(d, FRAME_CLEAN);
    // Spaces everywhere, then area code 1 blanks all three digits.
    d = '{8'h01, 8'h20, 8'h20, 8'h20, 8'h7f, 8'h55, 8'h2a, 8'h7d};
    push_frame(d, FRAME_CLEAN);
    // Dash in the tens place, space in units, area code 3, basic function zero.
    d = '{8'h80, 8'h00, 8'h2d, 8'h20, 8'h00, 8'h66, 8'h00, 8'h03};
    push_frame(d, FRAME_CLEAN);
    // All three digit bytes zero: the fallback leaves zero bytes that wrap below '0'.
    d = '{8'h42, 8'h00, 8'h00, 8'h00, 8'h21, 8'h01, 8'h7e, 8'hff};
    push_frame(d, FRAME_CLEAN);
    push_overlap();
    byte_feed.push_back(dft_pkg::STOP_BYTE);
    byte_feed.push_back(dft_pkg::START_BYTE);
    byte_feed.push_back(8'h00);
    byte_feed.push_back(8'hff);

    // Random part: mostly well-formed frames with random content, some with a broken
    // check, some overlapping, and short bursts of noise biased towards the markers.
    k = FEED_BYTES;
    while (byte_feed.size() < k) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        random_frame_data(d);
        push_frame(d, ($urandom_range(9) == 0) ? FRAME_HIGH_CHECK : FRAME_CLEAN);
      end else if (pick < 75) begin
        random_frame_data(d);
        push_frame(d, FRAME_BAD_CHECK);
      end else if (pick < 87) begin
        push_overlap();
      end else begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(3) == 0)
            byte_feed.push_back(($urandom_range(1) != 0) ? dft_pkg::STOP_BYTE :
                                                           dft_pkg::START_BYTE);
          else
            byte_feed.push_back(8'($urandom_range(255)));
        end
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (byte_feed.size() != 0 || in_valid) @(posedge clk);
    while (due_bytes.size() != 0) @(posedge clk);
    // Give a stray extra frame the chance to show itself before the verdict.
    repeat (40) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("display_frame_translator regression: pass");
    end else begin
      $display("display_frame_translator regression: fail");
    end
    $finish;
  end

endmodule
